### hdl/tts_pkg.sv
// Shared types, codes and constants of the timed task ready scheduler.
package tts_pkg;

   localparam int SLOTS_DEFAULT = 10;
   localparam int OP_W          = 3;
   localparam int SLOT_W        = 4;
   localparam int DELAY_W       = 16;
   localparam int COUNT_W       = 32;
   localparam int STATUS_W      = 2;

   localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
   localparam logic [OP_W-1:0] OP_START    = 3'd1;
   localparam logic [OP_W-1:0] OP_STOP     = 3'd2;
   localparam logic [OP_W-1:0] OP_DISPATCH = 3'd3;
   localparam logic [OP_W-1:0] OP_COMPLETE = 3'd4;
   localparam logic [OP_W-1:0] OP_INIT     = 3'd5;

   localparam logic [STATUS_W-1:0] ST_PENDING = 2'd0;
   localparam logic [STATUS_W-1:0] ST_READY   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RUNNING = 2'd2;

   localparam logic [COUNT_W-1:0] DEADLINE_IDLE = 32'hFFFF_FFFF;

   typedef struct packed {
      logic                enable;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  deadline;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{enable: 1'b0, status: ST_PENDING,
                                         deadline: DEADLINE_IDLE};

   typedef struct packed {
      logic               fire;
      logic [OP_W-1:0]    operation;
      logic [SLOT_W-1:0]  slot;
      logic [DELAY_W-1:0] delay;
   } item_type;

   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      entry_type         wr_data;
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              clear_all;
   } mem_cmd_type;

   typedef struct packed {
      logic               ready;
      logic               valid;
      logic               grant_valid;
      logic [SLOT_W-1:0]  grant_slot;
      logic [COUNT_W-1:0] system_count;
   } seq_status_type;

endpackage

### hdl/tts_if.sv
// Valid/ready channel interfaces for scheduler requests and responses.
interface tts_req_if;
   logic                        valid;
   logic                        ready;
   logic [tts_pkg::OP_W-1:0]    operation;
   logic [tts_pkg::SLOT_W-1:0]  slot;
   logic [tts_pkg::DELAY_W-1:0] delay;

   modport source (output valid, operation, slot, delay, input ready);
   modport sink (input valid, operation, slot, delay, output ready);
endinterface

interface tts_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        grant_valid;
   logic [tts_pkg::SLOT_W-1:0]  grant_slot;
   logic [tts_pkg::COUNT_W-1:0] system_count;

   modport source (output valid, grant_valid, grant_slot, system_count, input ready);
   modport sink (input valid, grant_valid, grant_slot, system_count, output ready);
endinterface

### hdl/tts_slot_table.sv
// Slot table memory with per-entry valid bits and a registered read port.
module tts_slot_table #(
   parameter int SLOTS = tts_pkg::SLOTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tts_pkg::mem_cmd_type cmd,
   output tts_pkg::entry_type   rd_entry
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   tts_pkg::entry_type mem [SLOTS];
   logic [SLOTS-1:0]   valid_ff;
   logic [SLOTS-1:0]   valid_in;
   tts_pkg::entry_type rdata_ff;
   logic               rvalid_ff;

   // An entry never written since reset or init reads as the idle entry.
   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear_all) begin
         valid_in = '0;
      end else if (cmd.wr_en) begin
         valid_in[cmd.wr_addr[AW-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff  <= mem[cmd.rd_addr[AW-1:0]];
         rvalid_ff <= valid_ff[cmd.rd_addr[AW-1:0]];
      end
   end

   assign rd_entry = rvalid_ff ? rdata_ff : tts_pkg::ENTRY_RESET;

endmodule

### hdl/tts_sequencer.sv
// Operation sequencer: counters, slot scans and read-modify-write of the table.
module tts_sequencer #(
   parameter int SLOTS = tts_pkg::SLOTS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tts_pkg::item_type       item,
   input  logic                    rsp_free,
   input  tts_pkg::entry_type      rd_entry,
   output tts_pkg::mem_cmd_type    cmd,
   output tts_pkg::seq_status_type status
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TICK = 3'd1;
   localparam logic [2:0] S_DISP = 3'd2;
   localparam logic [2:0] S_COMP = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]                  state_ff, state_in;
   logic [AW-1:0]               ptr_ff, ptr_in;
   logic [tts_pkg::COUNT_W-1:0] sched_ff, sched_in;
   logic [tts_pkg::COUNT_W-1:0] sys_ff, sys_in;
   logic                        gv_ff, gv_in;
   logic [tts_pkg::SLOT_W-1:0]  gs_ff, gs_in;
   logic                        in_range;
   tts_pkg::entry_type          wb_entry;

   assign in_range = {1'b0, item.slot} < (tts_pkg::SLOT_W + 1)'(SLOTS);

   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      sched_in = sched_ff;
      sys_in   = sys_ff;
      gv_in    = gv_ff;
      gs_in    = gs_ff;
      wb_entry = rd_entry;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (item.fire) begin
               gv_in    = 1'b0;
               gs_in    = '0;
               state_in = S_DONE;
               unique case (item.operation)
                  tts_pkg::OP_TICK: begin
                     sched_in    = sched_ff + 32'd1;
                     sys_in      = sys_ff + 32'd1;
                     cmd.rd_en   = 1'b1;
                     cmd.rd_addr = '0;
                     ptr_in      = '0;
                     state_in    = S_TICK;
                  end
                  tts_pkg::OP_START: begin
                     if (in_range) begin
                        cmd.wr_en            = 1'b1;
                        cmd.wr_addr          = item.slot;
                        cmd.wr_data.enable   = 1'b1;
                        cmd.wr_data.status   = (item.delay == '0) ? tts_pkg::ST_READY
                                                                  : tts_pkg::ST_PENDING;
                        cmd.wr_data.deadline = sched_ff
                                             + tts_pkg::COUNT_W'(item.delay);
                     end
                  end
                  tts_pkg::OP_STOP: begin
                     if (in_range) begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_addr = item.slot;
                        cmd.wr_data = tts_pkg::ENTRY_RESET;
                     end
                  end
                  tts_pkg::OP_DISPATCH: begin
                     cmd.rd_en   = 1'b1;
                     cmd.rd_addr = '0;
                     ptr_in      = '0;
                     state_in    = S_DISP;
                  end
                  tts_pkg::OP_COMPLETE: begin
                     if (in_range) begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = item.slot;
                        ptr_in      = item.slot[AW-1:0];
                        state_in    = S_COMP;
                     end
                  end
                  tts_pkg::OP_INIT: begin
                     cmd.clear_all = 1'b1;
                     sched_in      = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_TICK: begin
            // Entry at ptr_ff arrives now; the next entry is fetched in parallel.
            if (rd_entry.enable && (rd_entry.deadline <= sched_ff)) begin
               wb_entry.status = tts_pkg::ST_READY;
               cmd.wr_en       = 1'b1;
               cmd.wr_addr     = tts_pkg::SLOT_W'(ptr_ff);
               cmd.wr_data     = wb_entry;
            end
            if (ptr_ff == LAST) begin
               state_in = S_DONE;
            end else begin
               ptr_in      = ptr_ff + AW'(1);
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = tts_pkg::SLOT_W'(ptr_in);
            end
         end
         S_DISP: begin
            if (rd_entry.enable && (rd_entry.status == tts_pkg::ST_READY)) begin
               wb_entry.status = tts_pkg::ST_RUNNING;
               cmd.wr_en       = 1'b1;
               cmd.wr_addr     = tts_pkg::SLOT_W'(ptr_ff);
               cmd.wr_data     = wb_entry;
               gv_in           = 1'b1;
               gs_in           = tts_pkg::SLOT_W'(ptr_ff);
               state_in        = S_DONE;
            end else if (ptr_ff == LAST) begin
               state_in = S_DONE;
            end else begin
               ptr_in      = ptr_ff + AW'(1);
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = tts_pkg::SLOT_W'(ptr_in);
            end
         end
         S_COMP: begin
            if (rd_entry.status == tts_pkg::ST_RUNNING) begin
               wb_entry.enable = 1'b0;
               cmd.wr_en       = 1'b1;
               cmd.wr_addr     = tts_pkg::SLOT_W'(ptr_ff);
               cmd.wr_data     = wb_entry;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sched_ff <= '0;
         sys_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sched_ff <= sched_in;
         sys_ff   <= sys_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      gv_ff  <= gv_in;
      gs_ff  <= gs_in;
   end

   assign status.ready        = (state_ff == S_IDLE);
   assign status.valid        = (state_ff == S_DONE);
   assign status.grant_valid  = gv_ff;
   assign status.grant_slot   = gs_ff;
   assign status.system_count = sys_ff;

endmodule

### hdl/timed_task_ready_scheduler_core.sv
// Top level of the timed task ready scheduler: channels, response register, checks.
//
// The scheduler keeps SLOTS task slots (enable, status, 32-bit deadline) in a
// single-port-read synchronous slot table and executes one request transaction
// at a time: tick, start, stop, dispatch, complete or init. Every request
// produces exactly one response transaction carrying the grant (valid and slot,
// both zero unless a dispatch found an enabled ready slot) and the system count
// after the operation. Tick and dispatch walk the slot table one entry per
// cycle through its read port, writing back updated entries behind the read
// stream; a dispatch that hits early finishes sooner. A complete to a slot
// inside the table reads its entry and, if it is running, writes it back
// disabled, while start, stop, init, undefined codes and a complete to a
// slot outside the table go straight to the response. Init clears all slots
// through the table's valid bits and resets the scheduler count but not the
// system count. A response waits in an output register, so a new request is
// taken while the previous response is still being held; the block stalls
// only when a second response is ready before the first has been taken.
module timed_task_ready_scheduler_core #(
   parameter int SLOTS = tts_pkg::SLOTS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   tts_req_if.sink   req_chan,
   tts_rsp_if.source rsp_chan
);

   tts_pkg::item_type       item;
   tts_pkg::mem_cmd_type    cmd;
   tts_pkg::entry_type      rd_entry;
   tts_pkg::seq_status_type seq_status;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_gv_ff;
   logic [tts_pkg::SLOT_W-1:0]  rsp_gs_ff;
   logic [tts_pkg::COUNT_W-1:0] rsp_count_ff;
   logic                        rsp_free;
   logic                        rsp_load;

   // Request side: ready whenever the sequencer has no operation in flight.
   assign req_chan.ready = seq_status.ready;
   assign item.fire      = req_chan.valid && seq_status.ready;
   assign item.operation = req_chan.operation;
   assign item.slot      = req_chan.slot;
   assign item.delay     = req_chan.delay;

   // The output register is free when empty or when its transaction leaves now.
   assign rsp_free     = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load     = seq_status.valid && rsp_free;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);

   tts_sequencer #(
      .SLOTS(SLOTS)
   ) u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .item     (item),
      .rsp_free (rsp_free),
      .rd_entry (rd_entry),
      .cmd      (cmd),
      .status   (seq_status)
   );

   tts_slot_table #(
      .SLOTS(SLOTS)
   ) u_slot_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .rd_entry (rd_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_gv_ff    <= seq_status.grant_valid;
         rsp_gs_ff    <= seq_status.grant_slot;
         rsp_count_ff <= seq_status.system_count;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.grant_valid  = rsp_gv_ff;
   assign rsp_chan.grant_slot   = rsp_gs_ff;
   assign rsp_chan.system_count = rsp_count_ff;

`ifndef SYNTHESIS
   // A granted slot always lies inside the table.
   a_grant_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_gv_ff |-> ({1'b0, rsp_gs_ff} < (tts_pkg::SLOT_W + 1)'(SLOTS)))
      else $error("granted slot outside the slot table");

   // The write-back never targets the entry being read in the same cycle.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en && cmd.rd_en |-> cmd.wr_addr != cmd.rd_addr)
      else $error("slot table read and write collide on one entry");

   // Only one operation is in flight: a taken request closes the request side.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      item.fire |=> !req_chan.ready)
      else $error("request accepted while an operation is in flight");

   // A response is loaded only into a free output register.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rsp_valid_ff || rsp_chan.ready)
      else $error("pending response overwritten");
`endif

endmodule
